// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/qvr_pkg.sv =====
package qvr_pkg;

  localparam int VEC_WIDTH_DEF    = 16;
  localparam int NEWTON_STEPS_DEF = 3;

  localparam int QUAT_W = 16;  // quaternion component width
  localparam int M_W    = 30;  // normalized norm, Q30 in [1/4, 1)
  localparam int Y_W    = 32;  // inverse sqrt estimate, unsigned Q30

  localparam logic [32:0] THREE_Q30 = 33'h0_C000_0000;

  // 1/sqrt seed in Q12, placed in Q30, indexed by m[29:26]
  function automatic logic [Y_W-1:0] seed_q30(input logic [3:0] idx);
    logic [13:0] s;
    unique case (idx)
      4'd4:    s = 14'd7723;
      4'd5:    s = 14'd6986;
      4'd6:    s = 14'd6426;
      4'd7:    s = 14'd5983;
      4'd8:    s = 14'd5620;
      4'd9:    s = 14'd5316;
      4'd10:   s = 14'd5056;
      4'd11:   s = 14'd4831;
      4'd12:   s = 14'd4634;
      4'd13:   s = 14'd4459;
      4'd14:   s = 14'd4303;
      4'd15:   s = 14'd4162;
      default: s = 14'd8192;
    endcase
    return {s, 18'b0};
  endfunction

endpackage

// ===== sv/qvr_newton_step.sv =====
// One Newton step of 1/sqrt(m), three register stages:
//   y2 = y*y >> 30;  t = max(3<<30 - (m*y2 >> 30), 0);  y' = y*t >> 31
module qvr_newton_step (
  input  logic                    clk,
  input  logic                    en,
  input  logic [qvr_pkg::M_W-1:0] m_in,
  input  logic [qvr_pkg::Y_W-1:0] y_in,
  output logic [qvr_pkg::M_W-1:0] m_out,
  output logic [qvr_pkg::Y_W-1:0] y_out
);
  import qvr_pkg::*;

  logic [32:0]    y2_r;
  logic [Y_W-1:0] ya_r;
  logic [M_W-1:0] ma_r;
  logic [31:0]    t_r;
  logic [Y_W-1:0] yb_r;
  logic [M_W-1:0] mb_r;
  logic [Y_W-1:0] yc_r;
  logic [M_W-1:0] mc_r;

  logic [63:0] sq_prod;
  logic [62:0] my_prod;
  logic [32:0] my2;
  logic [31:0] t_nxt;
  logic [63:0] y_prod;

  always_comb begin
    sq_prod = y_in * y_in;
    my_prod = ma_r * y2_r;
    my2     = my_prod[62:30];
    if (my2 > THREE_Q30) begin
      t_nxt = '0;
    end else begin
      t_nxt = 32'(THREE_Q30 - my2);
    end
    y_prod = yb_r * t_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y2_r <= sq_prod[62:30];
      ya_r <= y_in;
      ma_r <= m_in;
      t_r  <= t_nxt;
      yb_r <= ya_r;
      mb_r <= ma_r;
      yc_r <= y_prod[62:31];
      mc_r <= mb_r;
    end
  end

  assign m_out = mc_r;
  assign y_out = yc_r;

endmodule

// ===== sv/quaternion_vector_rotate.sv =====
// Throughput: one request per cycle; the whole pipeline advances unless the
//   output register holds a result that is stalled.
// Stage count is set by the Newton iterations for 1/sqrt: three multiplier stages each.
// Reset (rst_n low, synchronous) clears the valid bits of every stage; data
//   registers are not reset.
`include "assert_macros.svh"

module quaternion_vector_rotate #(
  parameter int VEC_WIDTH    = qvr_pkg::VEC_WIDTH_DEF,
  parameter int NEWTON_STEPS = qvr_pkg::NEWTON_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [qvr_pkg::QUAT_W-1:0]  in_quat_x,
  input  logic [qvr_pkg::QUAT_W-1:0]  in_quat_y,
  input  logic [qvr_pkg::QUAT_W-1:0]  in_quat_z,
  input  logic [qvr_pkg::QUAT_W-1:0]  in_quat_w,
  input  logic [VEC_WIDTH-1:0]        in_vec_x,
  input  logic [VEC_WIDTH-1:0]        in_vec_y,
  input  logic [VEC_WIDTH-1:0]        in_vec_z,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [VEC_WIDTH-1:0]        out_rot_x,
  output logic [VEC_WIDTH-1:0]        out_rot_y,
  output logic [VEC_WIDTH-1:0]        out_rot_z,
  output logic                        out_degenerate,
  output logic                        out_saturated
);
  import qvr_pkg::*;

  // Unit quaternion is kept in Q(IFRAC); the final sum in Q(2*IFRAC).
  localparam int IFRAC = (59 - VEC_WIDTH) / 2;
  localparam int UW    = IFRAC + 2;          // unit quaternion component
  localparam int TW    = UW + VEC_WIDTH + 2; // t = 2 (u x v)
  localparam int TL    = TW / 2;             // low split of t for partial products
  localparam int TH    = TW - TL;
  localparam int PW    = UW + TW;            // full u*t product
  localparam int AW    = PW + 2;             // accumulator
  localparam int OW    = AW - 2 * IFRAC + 1; // rounded result before clamping
  localparam int NW    = 3 * NEWTON_STEPS;

  // Stage numbering (register stage index)
  localparam int S_N   = 1;       // norm sum
  localparam int S_M   = 2;       // normalize to [1/4, 1)
  localparam int S_P   = 4 + NW;  // q * y
  localparam int S_U   = 5 + NW;  // rounded unit quaternion
  localparam int S_C   = 6 + NW;  // u x v products
  localparam int S_ACC = 10 + NW; // v + w*t + u x t
  localparam int LAT   = 12 + NW;

  localparam logic signed [OW-1:0] OMAX = OW'((64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] OMIN = -OMAX - OW'(1);

  // Per-request data that rides alongside the arithmetic
  typedef struct packed {
    logic                            zero;
    logic [4:0]                      e;
    logic [3:0][QUAT_W-1:0]          q;
    logic [2:0][VEC_WIDTH-1:0]       v;
  } side_t;

  logic            adv;
  logic [LAT-1:0]  vld_r;
  side_t           side_r   [LAT-1];
  side_t           side_nxt [LAT-1];

  // Whole pipeline moves together; only a stalled result holds it.
  assign adv      = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Norm: squares, sum, then normalize n = m * 4^e with m in Q30
  // ---------------------------------------------------------------------
  logic [30:0]     sq_r [4];
  logic [32:0]     n_r;
  logic [32:0]     n_nxt;
  logic [5:0]      bl;
  logic [4:0]      e_nxt;
  logic [5:0]      two_e;
  logic [63:0]     n_ext;
  logic [M_W-1:0]  m_nxt;
  logic [M_W-1:0]  m_r;
  logic [M_W-1:0]  m0_r;
  logic [Y_W-1:0]  y0_r;
  logic signed [31:0] sq_prod [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_prod[i] = signed'(side_nxt[0].q[i]) * signed'(side_nxt[0].q[i]);
    end
    n_nxt = 33'(sq_r[0]) + 33'(sq_r[1]) + 33'(sq_r[2]) + 33'(sq_r[3]);
    // leading one position
    bl = '0;
    for (int b = 0; b < 33; b++) begin
      if (n_r[b]) begin
        bl = 6'(b + 1);
      end
    end
    e_nxt = 5'((7'(bl) + 7'd1) >> 1);
    two_e = {e_nxt, 1'b0};
    n_ext = 64'(n_r);
    if (two_e <= 6'd30) begin
      m_nxt = M_W'(n_ext << (6'd30 - two_e));
    end else begin
      m_nxt = M_W'(n_ext >> (two_e - 6'd30));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= sq_prod[i][30:0];
      end
      n_r  <= n_nxt;
      m_r  <= m_nxt;
      m0_r <= m_r;
      y0_r <= seed_q30(m_r[29:26]);
    end
  end

  // ---------------------------------------------------------------------
  // Side data line
  // ---------------------------------------------------------------------
  always_comb begin
    side_nxt[0].zero = 1'b0;
    side_nxt[0].e    = '0;
    side_nxt[0].q    = {in_quat_w, in_quat_z, in_quat_y, in_quat_x};
    side_nxt[0].v    = {in_vec_z, in_vec_y, in_vec_x};
    for (int s = 1; s < LAT - 1; s++) begin
      side_nxt[s] = side_r[s-1];
    end
    side_nxt[S_N].zero = (n_nxt == '0);
    side_nxt[S_M].e    = e_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < LAT - 1; s++) begin
        side_r[s] <= side_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Newton iterations for 1/sqrt(m)
  // ---------------------------------------------------------------------
  logic [M_W-1:0] nm [NEWTON_STEPS+1];
  logic [Y_W-1:0] ny [NEWTON_STEPS+1];

  assign nm[0] = m0_r;
  assign ny[0] = y0_r;

  for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
    qvr_newton_step u_step (
      .clk   (clk),
      .en    (adv),
      .m_in  (nm[g]),
      .y_in  (ny[g]),
      .m_out (nm[g+1]),
      .y_out (ny[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Scale q by y and round into Q(IFRAC)
  // ---------------------------------------------------------------------
  logic signed [48:0]  p_r  [4];
  logic signed [48:0]  p_nxt[4];
  logic signed [UW-1:0] u_nxt[4];
  logic signed [UW-1:0] u_r  [4];
  logic signed [UW-1:0] uc_r [4];
  logic signed [UW-1:0] ut_r [4];
  logic [5:0]          k;
  logic [48:0]         mag  [4];
  logic [48:0]         rnd  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p_nxt[i] = signed'(side_r[S_P-1].q[i]) * signed'({1'b0, ny[NEWTON_STEPS]});
    end
    k = 6'(side_r[S_U-1].e) + 6'(30 - IFRAC);
    for (int i = 0; i < 4; i++) begin
      mag[i]   = p_r[i][48] ? 49'(-p_r[i]) : 49'(p_r[i]);
      rnd[i]   = (mag[i] + (49'(1) << (k - 6'd1))) >> k;
      u_nxt[i] = p_r[i][48] ? UW'(-signed'(rnd[i])) : UW'(signed'(rnd[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= p_nxt;
      u_r  <= u_nxt;
      uc_r <= u_r;
      ut_r <= uc_r;
    end
  end

  // ---------------------------------------------------------------------
  // Rotation: t = 2 (u x v), r = u x t, acc = v*2^(2I) + w*t + r
  // ---------------------------------------------------------------------
  logic signed [UW+VEC_WIDTH-1:0] cp_r  [3][2];
  logic signed [TW-1:0]           t_r   [3];
  logic signed [UW+TH-1:0]        ph_r  [3][3];
  logic signed [UW+TL:0]          pl_r  [3][3];
  logic signed [PW-1:0]           wt_r  [3];
  logic signed [PW:0]             rr_r  [3];
  logic signed [AW-1:0]           acc_r [3];
  logic [VEC_WIDTH-1:0]           rot_r [3];
  logic                           deg_r;
  logic                           sat_r;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;

    logic signed [TW-1:0]   d;
    logic signed [TH-1:0]   th [3];
    logic signed [TL:0]     tl [3];
    logic signed [PW-1:0]   fp [3];
    logic signed [AW-1:0]   acc_nxt;

    always_comb begin
      d     = TW'(cp_r[i][0]) - TW'(cp_r[i][1]);
      th[0] = t_r[B][TW-1:TL];
      tl[0] = signed'({1'b0, t_r[B][TL-1:0]});
      th[1] = t_r[A][TW-1:TL];
      tl[1] = signed'({1'b0, t_r[A][TL-1:0]});
      th[2] = t_r[i][TW-1:TL];
      tl[2] = signed'({1'b0, t_r[i][TL-1:0]});
      for (int j = 0; j < 3; j++) begin
        fp[j] = (PW'(ph_r[i][j]) <<< TL) + PW'(pl_r[i][j]);
      end
      acc_nxt = (AW'(signed'(side_r[S_ACC-1].v[i])) <<< (2 * IFRAC))
              + AW'(wt_r[i]) + AW'(rr_r[i]);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cp_r[i][0] <= u_r[A] * signed'(side_r[S_C-1].v[B]);
        cp_r[i][1] <= u_r[B] * signed'(side_r[S_C-1].v[A]);
        t_r[i]     <= d <<< 1;
        ph_r[i][0] <= ut_r[A] * th[0];
        pl_r[i][0] <= ut_r[A] * tl[0];
        ph_r[i][1] <= ut_r[B] * th[1];
        pl_r[i][1] <= ut_r[B] * tl[1];
        ph_r[i][2] <= ut_r[3] * th[2];
        pl_r[i][2] <= ut_r[3] * tl[2];
        wt_r[i]    <= fp[2];
        rr_r[i]    <= (PW+1)'(fp[0]) - (PW+1)'(fp[1]);
        acc_r[i]   <= acc_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Round to integer, clamp, pick identity result for a zero norm
  // ---------------------------------------------------------------------
  logic [AW-1:0]          amag [3];
  logic [AW-1:0]          arnd [3];
  logic signed [OW-1:0]   o    [3];
  logic [VEC_WIDTH-1:0]   rot_nxt [3];
  logic [2:0]             clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = acc_r[i][AW-1] ? AW'(-acc_r[i]) : AW'(acc_r[i]);
      arnd[i] = (amag[i] + (AW'(1) << (2 * IFRAC - 1))) >> (2 * IFRAC);
      o[i]    = acc_r[i][AW-1] ? OW'(-signed'(arnd[i])) : OW'(signed'(arnd[i]));
      clip[i] = 1'b0;
      if (o[i] > OMAX) begin
        rot_nxt[i] = VEC_WIDTH'(OMAX);
        clip[i]    = 1'b1;
      end else if (o[i] < OMIN) begin
        rot_nxt[i] = VEC_WIDTH'(OMIN);
        clip[i]    = 1'b1;
      end else begin
        rot_nxt[i] = VEC_WIDTH'(o[i]);
      end
      if (side_r[LAT-2].zero) begin
        rot_nxt[i] = side_r[LAT-2].v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r <= rot_nxt;
      deg_r <= side_r[LAT-2].zero;
      sat_r <= !side_r[LAT-2].zero && (|clip);
    end
  end

  assign out_rot_x      = rot_r[0];
  assign out_rot_y      = rot_r[1];
  assign out_rot_z      = rot_r[2];
  assign out_degenerate = deg_r;
  assign out_saturated  = sat_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // an accepted request occupies the first stage next cycle
  `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, vld_r[0], "accepted request lost at pipeline entry")
  // a stalled result freezes every stage's valid bit
  `ASSERT_NEXT(a_stall_freezes, clk, rst_n, out_valid && out_stall, $stable(vld_r), "pipeline moved during output stall")
  // identity path never reports clipping
  `ASSERT_IMPL(a_deg_no_sat, clk, rst_n, out_valid && out_degenerate, !out_saturated, "degenerate result flagged saturated")

endmodule

// ===== sim/tb_quaternion_vector_rotate.sv =====
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;

  localparam int VW     = 16;
  localparam int IFRAC  = (59 - VW) / 2;
  localparam int NSTEPS = 3;
  localparam int NUM_RANDOM = 1650;

  // one request: q = (x, y, z, w), v = (x, y, z)
  typedef struct packed {
    logic [15:0] qx, qy, qz, qw;
    logic [VW-1:0] vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic [VW-1:0] rx, ry, rz;
    logic          degen;
    logic          sat;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic [VW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VW-1:0] out_rot_x, out_rot_y, out_rot_z;
  logic out_degenerate, out_saturated;

  always #5 clk = ~clk;

  quaternion_vector_rotate i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_quat_x      (in_quat_x),
    .in_quat_y      (in_quat_y),
    .in_quat_z      (in_quat_z),
    .in_quat_w      (in_quat_w),
    .in_vec_x       (in_vec_x),
    .in_vec_y       (in_vec_y),
    .in_vec_z       (in_vec_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rot_x      (out_rot_x),
    .out_rot_y      (out_rot_y),
    .out_rot_z      (out_rot_z),
    .out_degenerate (out_degenerate),
    .out_saturated  (out_saturated)
  );

  rot_req_t pending_reqs[$];   // filled by the stimulus block, drained by the driver
  rot_res_t expected_rots[$];  // predicted results, oldest first
  int       mismatches = 0;
  bit       stim_done = 1'b0;
  bit       drain_hold = 1'b0; // sender pauses until the pipe is empty
  bit       long_hold = 1'b0;  // receiver holds off for a long stretch

  // Round to nearest, ties away from zero, shifting right by s.
  function automatic longint round_shift(longint x, int s);
    longint mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (x < 0) ? -mag : mag;
  endfunction

  // 1/sqrt(m) for m in [1/4, 1) as Q30, seed table plus Newton steps.
  function automatic logic [63:0] rsqrt_q30(logic [63:0] m);
    logic [13:0] seed;
    logic [63:0] y, y2, my2, fac;
    case (m[29:26])
      4'd4: seed = 14'd7723;   4'd5: seed = 14'd6986;   4'd6: seed = 14'd6426;
      4'd7: seed = 14'd5983;   4'd8: seed = 14'd5620;   4'd9: seed = 14'd5316;
      4'd10: seed = 14'd5056;  4'd11: seed = 14'd4831;  4'd12: seed = 14'd4634;
      4'd13: seed = 14'd4459;  4'd14: seed = 14'd4303;  4'd15: seed = 14'd4162;
      default: seed = 14'd8192;
    endcase
    y = 64'(seed) << 18;
    for (int i = 0; i < NSTEPS; i++) begin
      y2  = (y * y) >> 30;
      my2 = (m * y2) >> 30;
      fac = (my2 > (64'd3 << 30)) ? 64'd0 : ((64'd3 << 30) - my2);
      y   = (y * fac) >> 31;
    end
    return y;
  endfunction

  // Expected rotation of one request.
  function automatic rot_res_t rotate_vec(rot_req_t rq);
    rot_res_t res;
    longint q[4], v[3], u[3], t[3], r[3], acc, o, w;
    logic [63:0] n, m, y, tmp;
    int bl, e, k;
    q[0] = longint'($signed(rq.qx)); q[1] = longint'($signed(rq.qy));
    q[2] = longint'($signed(rq.qz)); q[3] = longint'($signed(rq.qw));
    v[0] = longint'($signed(rq.vx)); v[1] = longint'($signed(rq.vy));
    v[2] = longint'($signed(rq.vz));
    n = 0;
    for (int i = 0; i < 4; i++) n += 64'(q[i] * q[i]);
    res = '0;
    if (n == 0) begin
      // zero norm: identity, vector passes through
      res.rx = rq.vx; res.ry = rq.vy; res.rz = rq.vz;
      res.degen = 1'b1;
      return res;
    end
    bl = 0; tmp = n;
    while (tmp != 0) begin bl++; tmp >>= 1; end
    e = (bl + 1) / 2;
    m = (2 * e <= 30) ? (n << (30 - 2 * e)) : (n >> (2 * e - 30));
    y = rsqrt_q30(m);
    k = e + 30 - IFRAC;
    for (int i = 0; i < 3; i++) u[i] = round_shift(q[i] * longint'(y), k);
    w = round_shift(q[3] * longint'(y), k);
    t[0] = 2 * (u[1] * v[2] - u[2] * v[1]);
    t[1] = 2 * (u[2] * v[0] - u[0] * v[2]);
    t[2] = 2 * (u[0] * v[1] - u[1] * v[0]);
    r[0] = u[1] * t[2] - u[2] * t[1];
    r[1] = u[2] * t[0] - u[0] * t[2];
    r[2] = u[0] * t[1] - u[1] * t[0];
    for (int i = 0; i < 3; i++) begin
      acc = v[i] * (64'sd1 <<< (2 * IFRAC)) + w * t[i] + r[i];
      o = round_shift(acc, 2 * IFRAC);
      if (o > 32767) begin o = 32767; res.sat = 1'b1; end
      if (o < -32768) begin o = -32768; res.sat = 1'b1; end
      case (i)
        0: res.rx = o[VW-1:0];
        1: res.ry = o[VW-1:0];
        default: res.rz = o[VW-1:0];
      endcase
    end
    return res;
  endfunction

  function automatic rot_req_t make_req(int qx, int qy, int qz, int qw,
                                        int vx, int vy, int vz);
    rot_req_t rq;
    rq.qx = qx[15:0]; rq.qy = qy[15:0]; rq.qz = qz[15:0]; rq.qw = qw[15:0];
    rq.vx = vx[VW-1:0]; rq.vy = vy[VW-1:0]; rq.vz = vz[VW-1:0];
    return rq;
  endfunction

  // Random component: mostly full range, sometimes half range, small or an extreme.
  function automatic int rand_comp();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(8)) - 4;
      2: return int'($urandom_range(32768)) - 16384;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Stimulus: directed corners, then random requests.
  initial begin
    rot_req_t rq;
    pending_reqs.push_back(make_req(0, 0, 0, 0, 100, -200, 300));         // zero norm
    pending_reqs.push_back(make_req(0, 0, 0, 0, -32768, 32767, -32768));
    pending_reqs.push_back(make_req(0, 0, 0, 16384, 1234, -5678, 32767)); // identity
    pending_reqs.push_back(make_req(0, 0, 16384, 0, 32767, 32767, 0));    // 180 about z
    pending_reqs.push_back(make_req(11585, 0, 0, 11585, 0, 1000, -1000)); // 90 about x
    pending_reqs.push_back(make_req(0, 0, 0, 1, 7, 8, 9));                // tiny norm
    pending_reqs.push_back(make_req(1, 0, 0, 0, 7, 8, 9));
    pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, 32767, -32768, 32767));
    pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, -32768, -32768, -32768));
    pending_reqs.push_back(make_req(8192, 8192, 8192, 8192, 32767, 32767, 32767)); // vector on the axis
    pending_reqs.push_back(make_req(-32768, 0, 0, 0, -32768, 32767, 1));
    pending_reqs.push_back(make_req(0, 32767, 0, 0, 32767, -1, -32768));
    pending_reqs.push_back(make_req(0, 0, -32768, 32767, -1, -1, -1));
    pending_reqs.push_back(make_req(3, -4, 5, -6, 0, 0, 0));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      rq.qx = 16'(rand_comp()); rq.qy = 16'(rand_comp());
      rq.qz = 16'(rand_comp()); rq.qw = 16'(rand_comp());
      if ($urandom_range(49) == 0) rq.qx = '0;
      if ($urandom_range(49) == 0) {rq.qx, rq.qy, rq.qz, rq.qw} = '0;
      rq.vx = VW'(rand_comp()); rq.vy = VW'(rand_comp()); rq.vz = VW'(rand_comp());
      pending_reqs.push_back(rq);
    end
    stim_done = 1'b1;
  end

  // Reset, then mid-run pressure events.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() < 1200);
    @(posedge clk);
    // drain pause: sender waits until nothing is outstanding
    drain_hold <= 1'b1;
    wait (expected_rots.size() == 0);
    @(posedge clk);
    drain_hold <= 1'b0;
    wait (pending_reqs.size() < 800);
    @(posedge clk);
    // long receiver hold-off so the pipe freezes and stalls the input
    long_hold <= 1'b1;
    repeat (150) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Driver: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_rots.push_back(rotate_vec(pending_reqs.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        // current request gone (or none): decide the next one
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !drain_hold) begin
          in_valid  <= 1'b1;
          in_quat_x <= pending_reqs[0].qx;
          in_quat_y <= pending_reqs[0].qy;
          in_quat_z <= pending_reqs[0].qz;
          in_quat_w <= pending_reqs[0].qw;
          in_vec_x  <= pending_reqs[0].vx;
          in_vec_y  <= pending_reqs[0].vy;
          in_vec_z  <= pending_reqs[0].vz;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(40);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: phases of free flow, light and heavy stalling.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(2);
      mode_left  <= $urandom_range(100, 10);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (long_hold) out_stall <= 1'b1;
    else case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3) == 0);
      default: out_stall <= ($urandom_range(3) != 0);
    endcase
  end

  // Monitor: compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    rot_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result rot=(%0d %0d %0d)",
          $signed(out_rot_x), $signed(out_rot_y), $signed(out_rot_z));
      end else begin
        want = expected_rots.pop_front();
        if (out_rot_x !== want.rx || out_rot_y !== want.ry || out_rot_z !== want.rz ||
            out_degenerate !== want.degen || out_saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rot=(%0d %0d %0d) deg=%b sat=%b, got (%0d %0d %0d) deg=%b sat=%b",
              $signed(want.rx), $signed(want.ry), $signed(want.rz), want.degen, want.sat,
              $signed(out_rot_x), $signed(out_rot_y), $signed(out_rot_z),
              out_degenerate, out_saturated);
        end
      end
    end
  end

  // End of run: all accepted, all results back, then an idle tail.
  initial begin
    wait (stim_done && pending_reqs.size() == 0 && expected_rots.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_rots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
